>>> hdl/dtpw_pkg.sv
// ---------------------------------------------------------------------------
// Depth-tested pixel writer: shared definitions
// Screen limits, field widths, command and status codes, item and pixel types.
// ---------------------------------------------------------------------------
package dtpw_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int PIXELS     = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(PIXELS);

  localparam int CFG_W   = 9;
  localparam int POS_W   = 16;
  localparam int DEPTH_W = 32;
  localparam int COL_W   = 8;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 3;

  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  // Register indexes on the configuration port.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_WRITTEN = 3'd0;
  localparam logic [STAT_W-1:0] STAT_OUTSIDE = 3'd1;
  localparam logic [STAT_W-1:0] STAT_DEPTH   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_CLEARED = 3'd3;
  localparam logic [STAT_W-1:0] STAT_READ    = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [DEPTH_W-1:0] depth_in;
    logic [COL_W-1:0]          red_in;
    logic [COL_W-1:0]          green_in;
    logic [COL_W-1:0]          blue_in;
    logic [COL_W-1:0]          alpha_in;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic [COL_W-1:0]          red_out;
    logic [COL_W-1:0]          green_out;
    logic [COL_W-1:0]          blue_out;
    logic [COL_W-1:0]          alpha_out;
    logic signed [DEPTH_W-1:0] depth_out;
    logic                      depth_empty;
  } out_item_t;

  // One stored pixel: empty flag, colour and depth in a single RAM word.
  typedef struct packed {
    logic                      empty;
    logic [COL_W-1:0]          alpha;
    logic [COL_W-1:0]          blue;
    logic [COL_W-1:0]          green;
    logic [COL_W-1:0]          red;
    logic signed [DEPTH_W-1:0] depth;
  } pix_t;

  typedef struct packed {
    logic              on_screen;
    logic [ADDR_W-1:0] idx;
  } addr_info_t;

endpackage

>>> hdl/depth_tested_pixel_writer_core.sv
// ---------------------------------------------------------------------------
// Depth-tested pixel writer
// Frame buffer with per-pixel depth test, clear with colour and pixel read.
// ---------------------------------------------------------------------------
//  channel   | dir | handshake            | payload
//  ----------+-----+----------------------+------------------------------------
//  in_       | in  | in_valid / in_stall  | in_data  (cmd, position, depth, RGBA)
//  out_      | out | out_valid / out_stall| out_data (status, RGBA, depth, empty)
//  cfg (APB) | in  | psel/penable/pready  | screen_width @ 0x0, screen_height @ 0x4
//
// A write, read or unknown item reads the pixel RAM in S_IDLE as it is taken;
// S_EXEC then tests, writes back and loads the result. This read-then-write on
// the single pixel RAM sets the rate. A clear item takes the same steps and
// then S_CLEAR, where the fill writes one pixel a cycle over the whole RAM.
// After reset S_INIT runs the same fill with black, empty pixels while in_stall
// stays high; configuration writes are taken at any time. A result waiting in
// the output register under out_stall does not stop the next item from being
// taken; only its final step waits for the register to free.
// ---------------------------------------------------------------------------
module depth_tested_pixel_writer_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dtpw_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dtpw_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam logic [1:0] S_INIT  = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_CLEAR = 2'd3;

  localparam logic [dtpw_pkg::ADDR_W-1:0] LAST_PIX =
    dtpw_pkg::ADDR_W'(dtpw_pkg::PIXELS - 1);

  logic [1:0]                  state_r, state_nxt;
  logic [dtpw_pkg::ADDR_W-1:0] sweep_r, sweep_nxt;
  logic [dtpw_pkg::CFG_W-1:0]  width_r, height_r;
  dtpw_pkg::in_item_t          item_r;
  dtpw_pkg::addr_info_t        addr_r;
  dtpw_pkg::addr_info_t        addr_info;
  logic                        out_valid_r, out_valid_nxt;
  dtpw_pkg::out_item_t         out_data_r;
  dtpw_pkg::out_item_t         result;

  logic                        accept;
  logic                        out_free;
  logic                        cfg_wr;
  logic                        depth_fail;
  logic                        rd_en;
  dtpw_pkg::pix_t              rd_pix;
  logic                        wr_en;
  logic [dtpw_pkg::ADDR_W-1:0] wr_addr;
  dtpw_pkg::pix_t              wr_pix;

  // -------------------------------------------------------------------------
  // Configuration port
  // -------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= dtpw_pkg::CFG_RESET;
      height_r <= dtpw_pkg::CFG_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == dtpw_pkg::REG_WIDTH) begin
        width_r <= pwdata[dtpw_pkg::CFG_W-1:0];
      end else begin
        height_r <= pwdata[dtpw_pkg::CFG_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == dtpw_pkg::REG_WIDTH) ? 32'(width_r) : 32'(height_r);

  // -------------------------------------------------------------------------
  // Address, RAM and item capture
  // -------------------------------------------------------------------------
  dtpw_addr_gen u_addr (
    .width_cfg  (width_r),
    .height_cfg (height_r),
    .pos_x      (in_data.pos_x),
    .pos_y      (in_data.pos_y),
    .info       (addr_info)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign rd_en    = accept;
  assign out_free = !out_valid_r || !out_stall;

  dtpw_pixel_ram u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (addr_info.idx),
    .rd_data (rd_pix),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_pix)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
      addr_r <= addr_info;
    end
  end

  // -------------------------------------------------------------------------
  // Depth test and result
  // -------------------------------------------------------------------------
  assign depth_fail = !rd_pix.empty && (rd_pix.depth > item_r.depth_in);

  always_comb begin
    result        = '0;
    result.status = dtpw_pkg::STAT_OUTSIDE;
    case (item_r.cmd)
      dtpw_pkg::CMD_WRITE: begin
        if (addr_r.on_screen) begin
          result.status = depth_fail ? dtpw_pkg::STAT_DEPTH : dtpw_pkg::STAT_WRITTEN;
        end
      end
      dtpw_pkg::CMD_CLEAR: begin
        result.status = dtpw_pkg::STAT_CLEARED;
      end
      dtpw_pkg::CMD_READ: begin
        if (addr_r.on_screen) begin
          result.status      = dtpw_pkg::STAT_READ;
          result.red_out     = rd_pix.red;
          result.green_out   = rd_pix.green;
          result.blue_out    = rd_pix.blue;
          result.alpha_out   = rd_pix.alpha;
          result.depth_out   = rd_pix.empty ? '0 : rd_pix.depth;
          result.depth_empty = rd_pix.empty;
        end
      end
      default: begin
        result.status = dtpw_pkg::STAT_OUTSIDE;
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // Sequencer and write port
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    sweep_nxt     = sweep_r;
    out_valid_nxt = out_valid_r && out_stall;
    wr_en         = 1'b0;
    wr_addr       = sweep_r;
    wr_pix        = '0;
    wr_pix.empty  = 1'b1;
    case (state_r)
      S_INIT: begin
        wr_en = 1'b1;
        if (sweep_r == LAST_PIX) begin
          sweep_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          wr_addr       = addr_r.idx;
          wr_pix.empty  = 1'b0;
          wr_pix.red    = item_r.red_in;
          wr_pix.green  = item_r.green_in;
          wr_pix.blue   = item_r.blue_in;
          wr_pix.alpha  = item_r.alpha_in;
          wr_pix.depth  = item_r.depth_in;
          wr_en         = (item_r.cmd == dtpw_pkg::CMD_WRITE) && addr_r.on_screen
                          && !depth_fail;
          state_nxt     = (item_r.cmd == dtpw_pkg::CMD_CLEAR) ? S_CLEAR : S_IDLE;
        end
      end
      S_CLEAR: begin
        // Fill every pixel, active area or not, with the clear colour.
        wr_en        = 1'b1;
        wr_pix.red   = item_r.red_in;
        wr_pix.green = item_r.green_in;
        wr_pix.blue  = item_r.blue_in;
        wr_pix.alpha = item_r.alpha_in;
        if (sweep_r == LAST_PIX) begin
          sweep_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_INIT;
        sweep_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_EXEC) && out_free) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/dtpw_addr_gen.sv
// ---------------------------------------------------------------------------
// Depth-tested pixel writer: address generator
// Clamps the screen size, checks bounds and forms the row-major pixel index.
// ---------------------------------------------------------------------------
module dtpw_addr_gen (
  input  logic [dtpw_pkg::CFG_W-1:0]        width_cfg,
  input  logic [dtpw_pkg::CFG_W-1:0]        height_cfg,
  input  logic signed [dtpw_pkg::POS_W-1:0] pos_x,
  input  logic signed [dtpw_pkg::POS_W-1:0] pos_y,
  output dtpw_pkg::addr_info_t              info
);

  localparam int PROD_W = dtpw_pkg::POS_W + dtpw_pkg::CFG_W;

  logic [dtpw_pkg::CFG_W-1:0] w_eff;
  logic [dtpw_pkg::CFG_W-1:0] h_eff;
  logic [PROD_W-1:0]          row_base;
  logic [PROD_W-1:0]          pix_sum;

  // A size of zero acts as one; anything above the maximum acts as the maximum.
  always_comb begin
    if (width_cfg == '0) begin
      w_eff = dtpw_pkg::CFG_W'(1);
    end else if (32'(width_cfg) > 32'(dtpw_pkg::MAX_WIDTH)) begin
      w_eff = dtpw_pkg::CFG_W'(dtpw_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_cfg;
    end
    if (height_cfg == '0) begin
      h_eff = dtpw_pkg::CFG_W'(1);
    end else if (32'(height_cfg) > 32'(dtpw_pkg::MAX_HEIGHT)) begin
      h_eff = dtpw_pkg::CFG_W'(dtpw_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_cfg;
    end
  end

  assign row_base = PROD_W'($unsigned(pos_y)) * PROD_W'(w_eff);
  assign pix_sum  = row_base + PROD_W'($unsigned(pos_x));

  assign info.on_screen = !pos_x[dtpw_pkg::POS_W-1] && !pos_y[dtpw_pkg::POS_W-1]
                          && ($unsigned(pos_x) < dtpw_pkg::POS_W'(w_eff))
                          && ($unsigned(pos_y) < dtpw_pkg::POS_W'(h_eff));
  assign info.idx       = pix_sum[dtpw_pkg::ADDR_W-1:0];

endmodule

>>> hdl/dtpw_pixel_ram.sv
// ---------------------------------------------------------------------------
// Depth-tested pixel writer: pixel RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module dtpw_pixel_ram (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [dtpw_pkg::ADDR_W-1:0] rd_addr,
  output dtpw_pkg::pix_t              rd_data,
  input  logic                        wr_en,
  input  logic [dtpw_pkg::ADDR_W-1:0] wr_addr,
  input  dtpw_pkg::pix_t              wr_data
);

  dtpw_pkg::pix_t mem [dtpw_pkg::PIXELS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> dv/tb_top.sv
// ---------------------------------------------------------------------------
// Depth-tested pixel writer testbench
// Drives write, clear, read and unknown items through the core across a
// range of screen sizes set over the APB port. A shadow z-buffer predicts
// every result, and each returned item is compared field by field with it.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [dtpw_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  localparam int CYCLE_LIMIT     = 3_000_000;
  localparam int PHASES          = 9;
  localparam int ITEMS_PER_PHASE = 215;
  localparam int HOLD_AFTER      = 520;
  localparam int HOLD_CYCLES     = 300;
  localparam int CALM_PHASE      = 3;

  logic                clk      = 1'b0;
  logic                rst_n    = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  dtpw_pkg::in_item_t  in_data  = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  dtpw_pkg::out_item_t out_data;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [2:0]          paddr    = '0;
  logic [31:0]         pwdata   = '0;
  logic [31:0]         prdata;
  logic                pready;

  // Shadow z-buffer and its registers.
  logic [dtpw_pkg::DEPTH_W-1:0] zb_depth  [dtpw_pkg::PIXELS];
  logic [31:0]                  zb_colour [dtpw_pkg::PIXELS];
  bit                           zb_empty  [dtpw_pkg::PIXELS];
  logic [dtpw_pkg::CFG_W-1:0]   width_reg  = dtpw_pkg::CFG_RESET;
  logic [dtpw_pkg::CFG_W-1:0]   height_reg = dtpw_pkg::CFG_RESET;

  dtpw_pkg::in_item_t  pixel_cmds_q[$];
  dtpw_pkg::out_item_t pixel_results_q[$];

  logic [dtpw_pkg::CFG_W-1:0] phase_w [PHASES] = '{256, 1, 0, 511, 16, 256, 1, 37, 256};
  logic [dtpw_pkg::CFG_W-1:0] phase_h [PHASES] = '{256, 1, 0, 300, 8, 1, 256, 200, 256};

  logic calm          = 1'b0;
  logic receiver_hold = 1'b0;
  int   items_accepted  = 0;
  int   results_checked = 0;
  int   mismatch_count  = 0;
  int   cycle_count     = 0;
  int   status_count [8];

  depth_tested_pixel_writer_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int eff_dim(input logic [dtpw_pkg::CFG_W-1:0] raw, input int limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  // Works out the result of one item and updates the shadow z-buffer.
  function automatic dtpw_pkg::out_item_t zbuf_predict(input dtpw_pkg::in_item_t it);
    dtpw_pkg::out_item_t res;
    int                  sx, sy, w, h, idx;
    bit                  on_screen;
    res       = '0;
    sx        = $signed(it.pos_x);
    sy        = $signed(it.pos_y);
    w         = eff_dim(width_reg, dtpw_pkg::MAX_WIDTH);
    h         = eff_dim(height_reg, dtpw_pkg::MAX_HEIGHT);
    on_screen = sx >= 0 && sy >= 0 && sx < w && sy < h;
    idx       = on_screen ? sy * w + sx : 0;
    case (it.cmd)
      dtpw_pkg::CMD_WRITE: begin
        if (!on_screen) begin
          res.status = dtpw_pkg::STAT_OUTSIDE;
        end else if (!zb_empty[idx] && $signed(zb_depth[idx]) > $signed(it.depth_in)) begin
          res.status = dtpw_pkg::STAT_DEPTH;
        end else begin
          zb_depth[idx]  = it.depth_in;
          zb_empty[idx]  = 1'b0;
          zb_colour[idx] = {it.alpha_in, it.blue_in, it.green_in, it.red_in};
          res.status     = dtpw_pkg::STAT_WRITTEN;
        end
      end
      dtpw_pkg::CMD_CLEAR: begin
        for (int i = 0; i < dtpw_pkg::PIXELS; i++) begin
          zb_colour[i] = {it.alpha_in, it.blue_in, it.green_in, it.red_in};
          zb_empty[i]  = 1'b1;
        end
        res.status = dtpw_pkg::STAT_CLEARED;
      end
      dtpw_pkg::CMD_READ: begin
        if (!on_screen) begin
          res.status = dtpw_pkg::STAT_OUTSIDE;
        end else begin
          res.status      = dtpw_pkg::STAT_READ;
          {res.alpha_out, res.blue_out, res.green_out, res.red_out} = zb_colour[idx];
          res.depth_empty = zb_empty[idx];
          res.depth_out   = zb_empty[idx] ? '0 : zb_depth[idx];
        end
      end
      default: begin
        res.status = dtpw_pkg::STAT_OUTSIDE;
      end
    endcase
    return res;
  endfunction

  function automatic dtpw_pkg::in_item_t make_item(input logic [dtpw_pkg::CMD_W-1:0] cmd,
                                                   input int x, input int y,
                                                   input logic [31:0] z,
                                                   input logic [31:0] rgba);
    dtpw_pkg::in_item_t it;
    it.cmd      = cmd;
    it.pos_x    = x[15:0];
    it.pos_y    = y[15:0];
    it.depth_in = z;
    {it.alpha_in, it.blue_in, it.green_in, it.red_in} = rgba;
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("MISMATCH at result %0d: %s got %h, expected %h",
             results_checked, what, got, want);
  endtask

  // APB write in setup and access cycles, then a read back of the same register.
  task automatic write_reg(input logic idx, input logic [dtpw_pkg::CFG_W-1:0] value);
    logic [31:0] readback;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == dtpw_pkg::REG_WIDTH) width_reg = value;
    else height_reg = value;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== 32'(value)) report_mismatch("register read back", readback, 32'(value));
  endtask

  // Most positions fall in a small corner so that depth tests hit stored pixels.
  task automatic queue_random_items(input int count, input bit with_clear);
    dtpw_pkg::in_item_t it;
    int                 w, h, clear_slot, pick, sx, sy;
    w          = eff_dim(width_reg, dtpw_pkg::MAX_WIDTH);
    h          = eff_dim(height_reg, dtpw_pkg::MAX_HEIGHT);
    clear_slot = with_clear ? $urandom_range(count - 1) : -1;
    for (int n = 0; n < count; n++) begin
      it.red_in   = 8'($urandom);
      it.green_in = 8'($urandom);
      it.blue_in  = 8'($urandom);
      it.alpha_in = 8'($urandom);
      pick = $urandom_range(99);
      if (n == clear_slot) it.cmd = dtpw_pkg::CMD_CLEAR;
      else if (pick < 3) it.cmd = CMD_UNKNOWN;
      else if (pick < 33) it.cmd = dtpw_pkg::CMD_READ;
      else it.cmd = dtpw_pkg::CMD_WRITE;
      pick = $urandom_range(99);
      if (pick < 55) begin
        sx = $urandom_range((w < 4 ? w : 4) - 1);
        sy = $urandom_range((h < 4 ? h : 4) - 1);
      end else if (pick < 80) begin
        sx = $urandom_range(w - 1);
        sy = $urandom_range(h - 1);
      end else if (pick < 92) begin
        sx = $urandom_range(w - 1);
        sy = $urandom_range(h - 1);
        case ($urandom_range(3))
          0: sx = w;
          1: sy = h;
          2: sx = -1;
          default: sy = -1;
        endcase
      end else begin
        sx = $urandom;
        sy = $urandom;
      end
      it.pos_x = sx[15:0];
      it.pos_y = sy[15:0];
      pick = $urandom_range(99);
      if (pick < 35) it.depth_in = $urandom_range(6) - 3;
      else if (pick < 45) it.depth_in = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      else it.depth_in = $urandom;
      pixel_cmds_q.push_back(it);
    end
  endtask

  // Sender: offers queued items and predicts each one as it is taken.
  always @(posedge clk) begin : drive_proc
    dtpw_pkg::out_item_t predicted;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted = zbuf_predict(in_data);
        pixel_results_q.push_back(predicted);
        status_count[predicted.status]++;
        items_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pixel_cmds_q.size() > 0 && (calm || $urandom_range(99) >= 26)) begin
          in_valid <= 1'b1;
          in_data  <= pixel_cmds_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, and checks each result against the oldest prediction.
  always @(posedge clk) begin : check_proc
    dtpw_pkg::out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= receiver_hold || (!calm && $urandom_range(99) < 26);
      if (out_valid && !out_stall) begin
        results_checked++;
        if (pixel_results_q.size() == 0) begin
          report_mismatch("unexpected result, status", 32'(out_data.status), '0);
        end else begin
          want = pixel_results_q.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", 32'(out_data.status), 32'(want.status));
          if (out_data.red_out !== want.red_out)
            report_mismatch("red_out", 32'(out_data.red_out), 32'(want.red_out));
          if (out_data.green_out !== want.green_out)
            report_mismatch("green_out", 32'(out_data.green_out), 32'(want.green_out));
          if (out_data.blue_out !== want.blue_out)
            report_mismatch("blue_out", 32'(out_data.blue_out), 32'(want.blue_out));
          if (out_data.alpha_out !== want.alpha_out)
            report_mismatch("alpha_out", 32'(out_data.alpha_out), 32'(want.alpha_out));
          if (out_data.depth_out !== want.depth_out)
            report_mismatch("depth_out", out_data.depth_out, want.depth_out);
          if (out_data.depth_empty !== want.depth_empty)
            report_mismatch("depth_empty", 32'(out_data.depth_empty), 32'(want.depth_empty));
        end
      end
    end
  end

  // One long hold-off on the result side while items keep coming in.
  initial begin : hold_proc
    wait (items_accepted >= HOLD_AFTER);
    @(posedge clk);
    receiver_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    receiver_hold <= 1'b0;
  end

  always @(posedge clk) begin : watchdog_proc
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : main_proc
    for (int i = 0; i < dtpw_pkg::PIXELS; i++) begin
      zb_empty[i]  = 1'b1;
      zb_colour[i] = '0;
      zb_depth[i]  = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      write_reg(dtpw_pkg::REG_WIDTH, phase_w[p]);
      write_reg(dtpw_pkg::REG_HEIGHT, phase_h[p]);
      calm <= (p == CALM_PHASE);
      if (p == 0) begin
        // Corners, depth extremes, equal depth, off-screen edges and a clear.
        pixel_cmds_q.push_back(make_item(dtpw_pkg::CMD_READ, 0, 0, 0, 0));
        pixel_cmds_q.push_back(make_item(dtpw_pkg::CMD_WRITE, 0, 0, 0, 32'h1122_3344));
        pixel_cmds_q.push_back(make_item(dtpw_pkg::CMD_READ, 0, 0, 0, 0));
        pixel_cmds_q.push_back(make_item(dtpw_pkg::CMD_WRITE, 0, 0, 32'hffff_ffff,
                                         32'h5566_7788));
        pixel_cmds_q.push_back(make_item(dtpw_pkg::CMD_WRITE, 0, 0, 0, 32'h99aa_bbcc));
        pixel_cmds_q.push_back(make_item(dtpw_pkg::CMD_WRITE, 0, 0, 32'h7fff_ffff,
                                         32'hffff_ffff));
        pixel_cmds_q.push_back(make_item(dtpw_pkg::CMD_WRITE, 0, 0, 32'h8000_0000, 32'h0));
        pixel_cmds_q.push_back(make_item(dtpw_pkg::CMD_READ, 0, 0, 0, 0));
        pixel_cmds_q.push_back(make_item(dtpw_pkg::CMD_WRITE, 255, 255, 32'h8000_0000,
                                         32'hffff_ffff));
        pixel_cmds_q.push_back(make_item(dtpw_pkg::CMD_READ, 255, 255, 0, 0));
        pixel_cmds_q.push_back(make_item(dtpw_pkg::CMD_WRITE, 256, 0, 0, 32'h0102_0304));
        pixel_cmds_q.push_back(make_item(dtpw_pkg::CMD_WRITE, 0, 256, 0, 32'h0102_0304));
        pixel_cmds_q.push_back(make_item(dtpw_pkg::CMD_WRITE, -1, 0, 0, 32'h0102_0304));
        pixel_cmds_q.push_back(make_item(dtpw_pkg::CMD_WRITE, 0, -1, 0, 32'h0102_0304));
        pixel_cmds_q.push_back(make_item(dtpw_pkg::CMD_WRITE, -32768, 32767, 0,
                                         32'h0102_0304));
        pixel_cmds_q.push_back(make_item(dtpw_pkg::CMD_WRITE, 32767, -32768, 0,
                                         32'h0102_0304));
        pixel_cmds_q.push_back(make_item(dtpw_pkg::CMD_READ, -1, 5, 0, 0));
        pixel_cmds_q.push_back(make_item(dtpw_pkg::CMD_READ, 300, 300, 0, 0));
        pixel_cmds_q.push_back(make_item(CMD_UNKNOWN, 0, 0, 32'h1234_5678, 32'hdead_beef));
        pixel_cmds_q.push_back(make_item(dtpw_pkg::CMD_CLEAR, 5, -7, 32'h7fff_ffff,
                                         32'h80c0_e0f0));
        pixel_cmds_q.push_back(make_item(dtpw_pkg::CMD_READ, 0, 0, 0, 0));
        pixel_cmds_q.push_back(make_item(dtpw_pkg::CMD_READ, 255, 255, 0, 0));
        pixel_cmds_q.push_back(make_item(dtpw_pkg::CMD_WRITE, 0, 0, 32'h8000_0000,
                                         32'h0f0f_0f0f));
        pixel_cmds_q.push_back(make_item(dtpw_pkg::CMD_READ, 0, 0, 0, 0));
      end
      queue_random_items(ITEMS_PER_PHASE, p == 2 || p == 5 || p == 7);
      while (pixel_cmds_q.size() != 0 || in_valid || pixel_results_q.size() != 0)
        @(posedge clk);
      // Pause before the next screen size is set.
      repeat (4) @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (pixel_results_q.size() != 0)
      report_mismatch("results never returned", pixel_results_q.size(), '0);
    $display("Ran %0d items over %0d screen sizes: %0d written, %0d failed depth, %0d off screen",
             items_accepted, PHASES, status_count[dtpw_pkg::STAT_WRITTEN],
             status_count[dtpw_pkg::STAT_DEPTH], status_count[dtpw_pkg::STAT_OUTSIDE]);
    $display("Reads %0d, clears %0d; %0d results checked, %0d mismatches",
             status_count[dtpw_pkg::STAT_READ], status_count[dtpw_pkg::STAT_CLEARED],
             results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
